>>> design/lpd_pkg.sv
// Shared types, codes and reset values for the length-prefix deframer.
`default_nettype none

package lpd_pkg;

  localparam int unsigned LPD_FIFO_DEPTH = 4;
  localparam int unsigned HDR_BYTES = 2;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [CFG_INDEX_W-1:0] CFG_BYTE_ORDER = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CALLER_LIMIT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BUFFER_CAPACITY = 2'd2;

  localparam logic RST_BYTE_ORDER = 1'b0;
  localparam logic [15:0] RST_CALLER_LIMIT = 16'd4096;
  localparam logic [16:0] RST_BUFFER_CAPACITY = 17'd8192;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  localparam logic ORDER_BIG = 1'b0;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_SHORT = 2'd1;
  localparam logic [1:0] ERR_CAPACITY = 2'd2;
  localparam logic [1:0] ERR_LIMIT = 2'd3;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_first;
    logic       frame_last;
    logic [1:0] error_code;
  } result_t;

  // Results written into the output queue in one cycle (zero, one or two).
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage : lpd_pkg

`default_nettype wire

>>> design/lpd_ifs.sv
// Valid/ready channel interfaces for the deframer input and result streams.
`default_nettype none

interface lpd_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface : lpd_in_if

interface lpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_first;
  logic       frame_last;
  logic [1:0] error_code;

  modport source (output valid, output out_byte, output frame_first, output frame_last,
                  output error_code, input ready);
  modport sink (input valid, input out_byte, input frame_first, input frame_last,
                input error_code, output ready);
endinterface : lpd_out_if

`default_nettype wire

>>> design/length_prefix_deframer_unit.sv
// Top level of the length-prefix deframer: header check, frame tracking and output queue.
//
// The block cuts a received byte stream into frames. Every frame opens with a
// 16-bit length that counts its two header bytes; the byte order of that header
// is set by the byte_order register. Input transactions on in_ch carry either a
// stream byte or a restart request. The first header byte gives no result, the
// second gives both header bytes (or one error result), and each body byte gives
// one result, with frame_last on the final byte of the frame.
// After an error, bytes are dropped until a restart transaction arrives.
// Results of an input transaction appear on out_ch from the next cycle on; the
// byte path takes one input transaction per cycle while in_ch.ready is high, and
// the two results of a header drain from a four-entry result queue.
// in_ch.ready is low only when that queue could not hold two more results, which
// happens only when the receiver on out_ch stalls; no result is ever dropped.
// Configuration writes on cfg_* take effect at the next clock edge; the user does them
// only while the block is idle; it does not check this. A synchronous reset (rst_n
// low) empties the queue, returns to header hunting and loads the register reset values.
`default_nettype none

module length_prefix_deframer_unit
  import lpd_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = LPD_FIFO_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  lpd_in_if.sink                      in_ch,
  lpd_out_if.source                   out_ch,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [1:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_BODY,
    PH_ERROR
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [15:0] remaining_r, remaining_nxt;

  logic        byte_order_r;
  logic [15:0] caller_limit_r;
  logic [16:0] buffer_capacity_r;

  logic        accept;
  logic        room_for_two;
  logic [15:0] frame_len;
  logic [17:0] len_plus_hdr;
  logic [1:0]  hdr_err;
  logic [15:0] body_left;
  logic [15:0] rem_dec;
  push_t       push;
  result_t     head;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = room_for_two;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_order_r      <= RST_BYTE_ORDER;
      caller_limit_r    <= RST_CALLER_LIMIT;
      buffer_capacity_r <= RST_BUFFER_CAPACITY;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BYTE_ORDER:      byte_order_r      <= cfg_data[0];
        CFG_CALLER_LIMIT:    caller_limit_r    <= cfg_data[15:0];
        CFG_BUFFER_CAPACITY: buffer_capacity_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Header length and its checks; the lowest failing code wins.
  assign frame_len = (byte_order_r == ORDER_BIG) ? {held_r, in_ch.rx_byte}
                                                 : {in_ch.rx_byte, held_r};
  assign len_plus_hdr = {2'b00, frame_len} + 18'(HDR_BYTES);
  assign body_left = frame_len - 16'(HDR_BYTES);
  assign rem_dec = (remaining_r != 16'd0) ? remaining_r - 16'd1 : remaining_r;

  always_comb begin
    if (frame_len < 16'(HDR_BYTES)) begin
      hdr_err = ERR_SHORT;
    end else if (len_plus_hdr > {1'b0, buffer_capacity_r}) begin
      hdr_err = ERR_CAPACITY;
    end else if (frame_len >= caller_limit_r) begin
      hdr_err = ERR_LIMIT;
    end else begin
      hdr_err = ERR_NONE;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    held_nxt      = held_r;
    remaining_nxt = remaining_r;
    push          = '0;
    if (accept) begin
      if (in_ch.req_type == REQ_RESTART) begin
        phase_nxt     = PH_HUNT1;
        held_nxt      = 8'd0;
        remaining_nxt = 16'd0;
      end else begin
        case (phase_r)
          PH_HUNT1: begin
            held_nxt  = in_ch.rx_byte;
            phase_nxt = PH_HUNT2;
          end
          PH_HUNT2: begin
            if (hdr_err != ERR_NONE) begin
              push.cnt           = 2'd1;
              push.r0.error_code = hdr_err;
              phase_nxt          = PH_ERROR;
              remaining_nxt      = 16'd0;
            end else begin
              push.cnt            = 2'd2;
              push.r0.out_byte    = held_r;
              push.r0.frame_first = 1'b1;
              push.r1.out_byte    = in_ch.rx_byte;
              push.r1.frame_last  = (body_left == 16'd0);
              remaining_nxt       = body_left;
              phase_nxt           = (body_left == 16'd0) ? PH_HUNT1 : PH_BODY;
            end
          end
          PH_BODY: begin
            push.cnt           = 2'd1;
            push.r0.out_byte   = in_ch.rx_byte;
            push.r0.frame_last = (rem_dec == 16'd0);
            remaining_nxt      = rem_dec;
            if (rem_dec == 16'd0) begin
              phase_nxt = PH_HUNT1;
            end
          end
          default: begin
            // Error discard: bytes are dropped until a restart.
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT1;
      held_r      <= 8'd0;
      remaining_r <= 16'd0;
    end else begin
      phase_r     <= phase_nxt;
      held_r      <= held_nxt;
      remaining_r <= remaining_nxt;
    end
  end

  lpd_result_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .room_for_two (room_for_two),
    .pop_valid    (out_ch.valid),
    .pop_ready    (out_ch.ready),
    .pop_data     (head)
  );

  assign out_ch.out_byte    = head.out_byte;
  assign out_ch.frame_first = head.frame_first;
  assign out_ch.frame_last  = head.frame_last;
  assign out_ch.error_code  = head.error_code;

endmodule : length_prefix_deframer_unit

`default_nettype wire

>>> design/lpd_result_fifo.sv
// Small result queue that takes up to two results per cycle and gives one.
`default_nettype none

module lpd_result_fifo
  import lpd_pkg::*;
#(
  parameter int unsigned DEPTH = LPD_FIFO_DEPTH
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire push_t   push,
  output logic         room_for_two,
  output logic         pop_valid,
  input  wire logic    pop_ready,
  output result_t      pop_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 2);

  result_t mem [DEPTH];

  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr_p1;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == LAST_IDX) ? '0 : p + PW'(1);
  endfunction

  assign pop          = pop_valid && pop_ready;
  assign pop_valid    = (count_r != '0);
  assign room_for_two = (count_r <= ROOM_MAX);
  assign wr_ptr_p1    = ptr_inc(wr_ptr_r);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (push.cnt == 2'd1) begin
      wr_ptr_nxt = wr_ptr_p1;
    end else if (push.cnt == 2'd2) begin
      wr_ptr_nxt = ptr_inc(wr_ptr_p1);
    end
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CW'(push.cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr_p1] <= push.r1;
    end
  end

  assign pop_data = mem[rd_ptr_r];

endmodule : lpd_result_fifo

`default_nettype wire

>>> design/lpd_checker.sv
// Port-level assertions for the deframer and the bind that attaches them.
`default_nettype none

module lpd_checker
  import lpd_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       frame_first,
  input wire logic       frame_last,
  input wire logic [1:0] error_code
);

  // A stalled result transaction is not withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  // Error results carry no byte and no frame markers.
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (error_code != ERR_NONE) |-> (out_byte == 8'd0) && !frame_first && !frame_last)
    else $error("error result carries frame data");

  // The first header byte can never also close a frame.
  a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(frame_first && frame_last))
    else $error("first and last flagged on one result");

  // Reset empties the result queue.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule : lpd_checker

bind length_prefix_deframer_unit lpd_checker u_lpd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_byte    (out_ch.out_byte),
  .frame_first (out_ch.frame_first),
  .frame_last  (out_ch.frame_last),
  .error_code  (out_ch.error_code)
);

`default_nettype wire

>>> verif/tb_length_prefix_deframer_unit.sv
// Testbench for length_prefix_deframer_unit: frame predictor, result checker and stimulus.
`timescale 1ns / 100ps

import lpd_pkg::*;

class deframe_checker;
  typedef enum logic [1:0] {
    SEEK_FIRST,
    SEEK_SECOND,
    PASS_BODY,
    DROP_UNTIL_RESTART
  } seek_state_e;

  logic        order;
  logic [15:0] limit;
  logic [16:0] capacity;
  seek_state_e state;
  logic [7:0]  held_byte;
  logic [15:0] body_left;
  result_t     frame_bytes_q[$];
  int          mismatches;
  int          frames;
  int          rejects;

  function new();
    order       = RST_BYTE_ORDER;
    limit       = RST_CALLER_LIMIT;
    capacity    = RST_BUFFER_CAPACITY;
    state       = SEEK_FIRST;
    held_byte   = '0;
    body_left   = '0;
    mismatches  = 0;
    frames      = 0;
    rejects     = 0;
  endfunction

  function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_BYTE_ORDER:      order = data[0];
      CFG_CALLER_LIMIT:    limit = data[15:0];
      CFG_BUFFER_CAPACITY: capacity = data[16:0];
      default: ;
    endcase
  endfunction

  // Works out the results that one accepted transaction causes.
  function void deframe_item(logic req, logic [7:0] b);
    logic [15:0] len;
    logic [1:0]  code;
    result_t     r;
    if (req == REQ_RESTART) begin
      state     = SEEK_FIRST;
      held_byte = '0;
      body_left = '0;
      return;
    end
    case (state)
      SEEK_FIRST: begin
        held_byte = b;
        state     = SEEK_SECOND;
      end
      SEEK_SECOND: begin
        len = (order == ORDER_BIG) ? {held_byte, b} : {b, held_byte};
        if (len < HDR_BYTES) code = ERR_SHORT;
        else if (32'(len) + HDR_BYTES > 32'(capacity)) code = ERR_CAPACITY;
        else if (len >= limit) code = ERR_LIMIT;
        else code = ERR_NONE;
        if (code != ERR_NONE) begin
          r = '{out_byte: 8'h00, frame_first: 1'b0, frame_last: 1'b0, error_code: code};
          frame_bytes_q.push_back(r);
          body_left = '0;
          state     = DROP_UNTIL_RESTART;
          rejects++;
        end else begin
          body_left = len - 16'(HDR_BYTES);
          r = '{out_byte: held_byte, frame_first: 1'b1, frame_last: 1'b0, error_code: ERR_NONE};
          frame_bytes_q.push_back(r);
          r = '{out_byte: b, frame_first: 1'b0, frame_last: (body_left == 0),
                error_code: ERR_NONE};
          frame_bytes_q.push_back(r);
          state = (body_left == 0) ? SEEK_FIRST : PASS_BODY;
          frames++;
        end
      end
      PASS_BODY: begin
        if (body_left > 0) body_left = body_left - 1'b1;
        r = '{out_byte: b, frame_first: 1'b0, frame_last: (body_left == 0),
              error_code: ERR_NONE};
        frame_bytes_q.push_back(r);
        if (body_left == 0) state = SEEK_FIRST;
      end
      default: ;
    endcase
  endfunction

  function void check_field(string name, logic [7:0] want, logic [7:0] seen);
    if (seen !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, seen);
      mismatches++;
    end
  endfunction

  function void compare_output(logic [7:0] ob, logic first, logic last, logic [1:0] ec);
    result_t want;
    if (frame_bytes_q.size() == 0) begin
      $error("Result with nothing expected: out_byte %0h first %0b last %0b error %0d",
             ob, first, last, ec);
      mismatches++;
      return;
    end
    want = frame_bytes_q.pop_front();
    check_field("out_byte", want.out_byte, ob);
    check_field("frame_first", want.frame_first, first);
    check_field("frame_last", want.frame_last, last);
    check_field("error_code", want.error_code, ec);
  endfunction

  function int pending();
    return frame_bytes_q.size();
  endfunction
endclass

module tb_length_prefix_deframer_unit;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 11;
  // Results leave the block from the cycle after acceptance through a four-entry
  // queue, so SETTLE_CYCLES of waiting covers anything still in flight.
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam logic ORDER_LITTLE = ~ORDER_BIG;
  localparam int NUM_SETTINGS  = 7;

  // One register setting of the run, with the idling used while it is active.
  typedef struct {
    logic        order;
    logic [15:0] limit;
    logic [16:0] capacity;
    int          budget;
    bit          gaps;
    bit          stalls;
  } setting_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  lpd_in_if  in_ch ();
  lpd_out_if out_ch ();

  deframe_checker sb;
  setting_t       plan[NUM_SETTINGS];

  bit          in_gaps;
  bit          out_stalls;
  int          stall_left = 0;
  int          stream_items = 0;
  int          discarded_items = 0;
  int unsigned cycle_count = 0;

  length_prefix_deframer_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Watchdog: a hang anywhere in the handshakes ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, sb.pending());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: ready changes on the falling edge. When stalls are enabled, it drops
  // ready now and then for a burst of random length; otherwise it is always ready.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (out_stalls && $urandom_range(0, 4) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 5);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Every result transaction is checked against the oldest predicted result.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.compare_output(out_ch.out_byte, out_ch.frame_first, out_ch.frame_last,
                        out_ch.error_code);
    end
  end

  // Offers one input transaction, optionally after an idle burst, and returns on
  // the falling edge that follows its acceptance. Each call starts on a falling
  // edge, so valid is never assigned twice in one time step.
  task automatic put_stream_item(input logic req, input logic [7:0] b);
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= req;
    in_ch.rx_byte  <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.deframe_item(req, b);
    stream_items++;
    @(negedge clk);
  endtask

  task automatic put_restart();
    put_stream_item(REQ_RESTART, 8'($urandom_range(0, 255)));
  endtask

  // The header goes out in the byte order the block is currently set to.
  task automatic send_header(input logic [15:0] len);
    if (sb.order == ORDER_BIG) begin
      put_stream_item(REQ_BYTE, len[15:8]);
      put_stream_item(REQ_BYTE, len[7:0]);
    end else begin
      put_stream_item(REQ_BYTE, len[7:0]);
      put_stream_item(REQ_BYTE, len[15:8]);
    end
  endtask

  task automatic send_frame(input int len);
    send_header(16'(len));
    for (int i = 0; i < len - 2; i++) put_stream_item(REQ_BYTE, 8'($urandom_range(0, 255)));
  endtask

  // Withdraws the input, waits until every predicted result has come out, then
  // lets the block settle.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes all three registers on consecutive cycles; write enable stays high
  // across them and drops once at the end.
  task automatic load_settings(input setting_t s);
    logic [CFG_INDEX_W-1:0] idx[3];
    logic [CFG_DATA_W-1:0]  val[3];
    idx = '{CFG_BYTE_ORDER, CFG_CALLER_LIMIT, CFG_BUFFER_CAPACITY};
    val = '{CFG_DATA_W'(s.order), CFG_DATA_W'(s.limit), CFG_DATA_W'(s.capacity)};
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      sb.set_register(idx[i], val[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // A frame length the current settings accept, or -1 if none passes.
  // Mostly short frames, now and then the longest one when it is cheap enough.
  function automatic int good_length();
    int top;
    top = int'(sb.limit) - 1;
    if (int'(sb.capacity) - 2 < top) top = int'(sb.capacity) - 2;
    if (top < 2) return -1;
    if (top <= 160 && $urandom_range(0, 6) == 0) return top;
    return 2 + int'($urandom_range(0, (top - 2 < 14) ? top - 2 : 14));
  endfunction

  // A length aimed at one of the three header checks, or an arbitrary one.
  function automatic logic [15:0] bad_length();
    int cap_edge;
    cap_edge = int'(sb.capacity) - 1;
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return (sb.limit >= 2) ? sb.limit : 16'h0001;
      3: return (cap_edge >= 2 && cap_edge <= 65535) ? 16'(cap_edge) : 16'hFFFF;
      4: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Extremes first: the shortest and zero lengths, a header-only frame, a length
  // exactly at the caller limit, an oversized length, and restarts that cut a
  // header and a body short. Runs on the reset register values.
  task automatic run_directed();
    send_header(16'h0000);              // length zero is rejected as too short
    put_stream_item(REQ_BYTE, 8'hFF);   // dropped while waiting for a restart
    put_stream_item(REQ_RESTART, 8'hA5);
    send_header(16'h0001);              // length one is rejected as well
    put_restart();
    send_header(16'h0002);              // header only: second byte is the last
    send_header(16'h0003);
    put_stream_item(REQ_BYTE, 8'h00);
    send_header(16'h1000);              // equal to the caller limit
    put_restart();
    send_header(16'hFFFF);              // fails capacity and limit; capacity wins
    put_restart();
    put_stream_item(REQ_BYTE, 8'h00);   // restart between the two header bytes
    put_restart();
    send_header(16'h0005);              // restart in the middle of a body
    put_stream_item(REQ_BYTE, 8'h7E);
    put_restart();
  endtask

  // Random traffic for one setting. Most sequences are well-formed frames with
  // random contents; the rest are rejected headers, truncated frames and line
  // noise, each closed by a restart so the next frame starts in sync.
  task automatic run_random(input int budget);
    int start_count;
    int pick;
    int good;
    int cut;
    start_count = stream_items - discarded_items;
    while (stream_items - discarded_items - start_count < budget) begin
      pick = $urandom_range(0, 99);
      good = good_length();
      if (pick < 60 && good >= 2) begin
        send_frame(good);
      end else if (pick < 78 || (pick < 60 && good < 2)) begin
        send_header(bad_length());
        repeat ($urandom_range(0, 3)) begin
          put_stream_item(REQ_BYTE, 8'($urandom_range(0, 255)));
          discarded_items++;
        end
        put_restart();
      end else if (pick < 88) begin
        if (good < 3 || $urandom_range(0, 2) == 0) begin
          put_stream_item(REQ_BYTE, 8'($urandom_range(0, 255)));
        end else begin
          send_header(16'(good));
          cut = $urandom_range(0, good - 3);
          for (int i = 0; i < cut; i++) put_stream_item(REQ_BYTE, 8'($urandom_range(0, 255)));
        end
        put_restart();
      end else if (pick < 96) begin
        repeat ($urandom_range(1, 4)) put_stream_item(REQ_BYTE, 8'($urandom_range(0, 255)));
        put_restart();
      end else begin
        put_restart();
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.req_type = REQ_BYTE;
    in_ch.rx_byte  = 8'h00;
    out_ch.ready   = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_BYTE_ORDER;
    cfg_data       = '0;
    in_gaps        = 1'b1;
    out_stalls     = 1'b1;
    sb             = new();

    // Settings cover both byte orders, a caller limit of zero and of its maximum,
    // a capacity at its maximum, at its minimum and below its range, and small
    // limits where the limit and capacity edges are reached with short frames.
    // The last setting runs without any idling on either side.
    plan = '{
      '{ORDER_LITTLE, 16'd20,    17'd24,    50, 1'b1, 1'b1},
      '{ORDER_BIG,    16'd0,     17'd65537, 30, 1'b1, 1'b0},
      '{ORDER_LITTLE, 16'd65535, 17'd65537, 50, 1'b0, 1'b1},
      '{ORDER_BIG,    16'd12,    17'd2,     30, 1'b1, 1'b1},
      '{ORDER_BIG,    16'd40,    17'd4,     40, 1'b0, 1'b0},
      '{ORDER_LITTLE, 16'd300,   17'd150,   50, 1'b1, 1'b1},
      '{ORDER_BIG,    16'd4096,  17'd8192,  50, 1'b0, 1'b0}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    run_directed();

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      settle();
      load_settings(plan[p]);
      in_gaps    = plan[p].gaps;
      out_stalls = plan[p].stalls;
      // One long frame while the limits are at their widest.
      if (plan[p].limit == 16'hFFFF) send_frame($urandom_range(100, 200));
      run_random(plan[p].budget);
    end

    settle();

    $display("Drove %0d stream transactions, restarts included, through %0d register settings.",
             stream_items, NUM_SETTINGS + 1);
    $display("Predicted %0d accepted frame headers and %0d rejected ones; %0d mismatches.",
             sb.frames, sb.rejects, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
